@@ rtl/sfl_pkg.sv @@
// Package for the serial flash loader sequencer.
// Holds field widths, reset values, register indexes and the enum types.
// No dependencies.
package sfl_pkg;

	localparam int ADDR_W = 13;
	localparam int WORD_W = 14;
	localparam int TICK_W = 20;
	localparam int RETRY_W = 4;
	localparam int BYTE_W = 8;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 20'd380000;
	localparam logic [RETRY_W-1:0] RETRIES_RST = 4'd3;
	localparam logic [ADDR_W-1:0] REGION_START_RST = 13'h0600;
	localparam logic [ADDR_W-1:0] REGION_END_RST = 13'h0FFF;

	localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TIMEOUT      = 2'd0,
		REG_MAX_RETRIES  = 2'd1,
		REG_REGION_START = 2'd2,
		REG_REGION_END   = 2'd3
	} cfg_reg_t;

	// Result event codes.
	typedef enum logic [2:0] {
		EV_HS_OK      = 3'd0,
		EV_ERASE      = 3'd1,
		EV_WRITE      = 3'd2,
		EV_DONE       = 3'd3,
		EV_PKT_TO     = 3'd4,
		EV_ABORT      = 3'd5,
		EV_HS_TO      = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		PH_HANDSHAKE = 2'd0,
		PH_LOAD      = 2'd1,
		PH_STOPPED   = 2'd2
	} phase_t;

	// What a group of results caused by one input looks like.
	typedef enum logic [2:0] {
		GRP_HS_TO    = 3'd0,
		GRP_HS_OK    = 3'd1,
		GRP_PKT_TO   = 3'd2,
		GRP_ABORT    = 3'd3,
		GRP_PKT      = 3'd4,
		GRP_PKT_DONE = 3'd5
	} grp_kind_t;

endpackage

@@ rtl/serial_flash_loader_sequencer_unit.sv @@
// Top level of the serial flash loader sequencer.
// Depends on sfl_pkg for widths, reset values, codes and enum types.
//
// Usage. The slave stream carries one event per request: tuser[0] is the
// kind (0 = received byte, 1 = one idle tick) and tdata[7:0] the byte. The
// block first waits for the sync pair 0x55, 0xAA; it then reports success,
// requests an erase of the application region and collects packets of
// 2*WORDS_PER_BLOCK bytes. Each full packet becomes WORDS_PER_BLOCK word
// writes at consecutive addresses of an aligned block, followed by a
// completion report after the block that ends the region. Idle ticks count
// toward the handshake and packet timeouts.
// The master stream carries one result per request: tuser holds the event
// code, tdata the word address and word value, and tlast marks the final
// result caused by one input event.
// An accepted event waits in the input register until the result group
// register is free. Throughput: one event per cycle while events cause no
// results. An event with n results holds the result group register until
// all n are taken (WORDS_PER_BLOCK + 1 at most, on a packet that closes the
// region); later events wait behind it, the next one in the input register.
// When the receiver stalls, the result group and the input register hold and
// tready drops; nothing is lost. Reset clears all control state and loads the
// configuration defaults. The cfg channel is always ready; the user writes it
// only while the block is idle, and the block itself does not enforce this.
module serial_flash_loader_sequencer_unit #(
	parameter int WORDS_PER_BLOCK = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// Event input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tuser,   // [0] event_kind
	// Result output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [12:0] word_address, [26:13] word_value, zero above
	output logic [2:0]  m_axis_tuser,   // [2:0] event_code
	output logic        m_axis_tlast
);

	localparam int AW = sfl_pkg::ADDR_W;
	localparam int PKT_BYTES = 2 * WORDS_PER_BLOCK;
	localparam int BCW = $clog2(PKT_BYTES);
	localparam int IDXW = $clog2(WORDS_PER_BLOCK + 1);
	localparam int WIDX = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
	// Width for the end-of-region check: address plus up to two blocks.
	localparam int EW = AW + $clog2(PKT_BYTES) + 1;
	// Reciprocal for the block number: floor(a / W) = (a * RECIP) >> RSH,
	// exact for every 13-bit address.
	localparam int RSH = AW + $clog2(WORDS_PER_BLOCK);
	localparam int RECIP_INT = ((1 << RSH) + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK;
	localparam int RW = RSH + 1;
	localparam logic [RW-1:0] RECIP = RW'(RECIP_INT);
	localparam int PW = AW + RW;

	// Configuration registers.
	logic [sfl_pkg::TICK_W-1:0]  timeout_q;
	logic [sfl_pkg::RETRY_W-1:0] max_retries_q;
	logic [AW-1:0]               region_start_q;
	logic [AW-1:0]               region_end_q;

	// Input register.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// Sequencer state.
	sfl_pkg::phase_t             phase_q, phase_d;
	logic [7:0]                  prev_byte_q, prev_byte_d;
	logic [sfl_pkg::TICK_W-1:0]  tick_cnt_q, tick_cnt_d;
	logic [BCW-1:0]              byte_cnt_q, byte_cnt_d;
	logic [7:0]                  pkt_byte_q [PKT_BYTES];
	logic [sfl_pkg::RETRY_W-1:0] retry_cnt_q, retry_cnt_d;
	logic [AW-1:0]               wr_addr_q, wr_addr_d;
	logic [AW-1:0]               blk_q, blk_d;

	// Result group register: one group per input event with results, drained one
	// result per cycle while the receiver is ready.
	logic                   grp_valid_q;
	sfl_pkg::grp_kind_t     grp_kind_q, grp_kind_d;
	logic [IDXW-1:0]        grp_idx_q;
	logic [AW-1:0]          grp_addr_q, grp_addr_d;
	logic [sfl_pkg::WORD_W-1:0] grp_word_q [WORDS_PER_BLOCK];
	logic [sfl_pkg::WORD_W-1:0] grp_word_d [WORDS_PER_BLOCK];
	logic                   grp_load;

	logic                   adv_s1;
	logic                   slot_free;
	logic                   out_fire;
	logic [IDXW-1:0]        last_idx;

	logic [sfl_pkg::TICK_W-1:0]  tick_inc;
	logic                        tick_hit;
	logic [sfl_pkg::RETRY_W-1:0] retry_inc;
	logic                        pkt_full;
	logic [EW-1:0]               end_sum;
	logic                        region_done;
	logic [PW-1:0]               blk_prod;

	sfl_pkg::event_t        out_code;
	logic [AW-1:0]          out_addr;
	logic [sfl_pkg::WORD_W-1:0] out_word;

	// ------------------------------------------------------------------
	// Configuration port: always ready; the user writes it only while idle (not enforced).
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= sfl_pkg::TIMEOUT_RST;
			max_retries_q  <= sfl_pkg::RETRIES_RST;
			region_start_q <= sfl_pkg::REGION_START_RST;
			region_end_q   <= sfl_pkg::REGION_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (sfl_pkg::cfg_reg_t'(cfg_index))
				sfl_pkg::REG_TIMEOUT:      timeout_q      <= cfg_data;
				sfl_pkg::REG_MAX_RETRIES:  max_retries_q  <= cfg_data[sfl_pkg::RETRY_W-1:0];
				sfl_pkg::REG_REGION_START: region_start_q <= cfg_data[AW-1:0];
				sfl_pkg::REG_REGION_END:   region_end_q   <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake between input register and result group register.
	// ------------------------------------------------------------------
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign slot_free     = !grp_valid_q || (out_fire && (grp_idx_q == last_idx));
	assign adv_s1        = valid_s1 && slot_free;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// ------------------------------------------------------------------
	// Shared arithmetic for the current event.
	// ------------------------------------------------------------------
	// The tick counter saturates rather than wrapping.
	assign tick_inc  = (&tick_cnt_q) ? tick_cnt_q : tick_cnt_q + 1'b1;
	assign tick_hit  = tick_inc >= timeout_q;
	assign retry_inc = (&retry_cnt_q) ? retry_cnt_q : retry_cnt_q + 1'b1;
	assign pkt_full  = byte_cnt_q == BCW'(PKT_BYTES - 1);
	// Completion when the block after this one would run past the region end.
	assign end_sum     = EW'(wr_addr_q) + EW'(PKT_BYTES - 1);
	assign region_done = end_sum > EW'(region_end_q);
	assign blk_prod    = PW'(region_start_q) * PW'(RECIP);

	// Words of a finished packet, little-endian; the high byte keeps six bits.
	// The closing byte comes straight from the input register.
	always_comb begin
		for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
			if (i == WORDS_PER_BLOCK - 1) begin
				grp_word_d[i] = {byte_s1[5:0], pkt_byte_q[2*i]};
			end else begin
				grp_word_d[i] = {pkt_byte_q[2*i+1][5:0], pkt_byte_q[2*i]};
			end
		end
	end

	// ------------------------------------------------------------------
	// Next-state logic of the sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		phase_d     = phase_q;
		prev_byte_d = prev_byte_q;
		tick_cnt_d  = tick_cnt_q;
		byte_cnt_d  = byte_cnt_q;
		retry_cnt_d = retry_cnt_q;
		wr_addr_d   = wr_addr_q;
		blk_d       = blk_q;
		case (phase_q)
			sfl_pkg::PH_HANDSHAKE: begin
				if (kind_s1) begin
					tick_cnt_d = tick_inc;
					if (tick_hit) begin
						phase_d = sfl_pkg::PH_STOPPED;
					end
				end else if (prev_byte_q == sfl_pkg::SYNC_FIRST &&
						byte_s1 == sfl_pkg::SYNC_SECOND) begin
					phase_d     = sfl_pkg::PH_LOAD;
					tick_cnt_d  = '0;
					byte_cnt_d  = '0;
					retry_cnt_d = '0;
					wr_addr_d   = region_start_q;
					blk_d       = blk_prod[RSH +: AW];
				end else begin
					prev_byte_d = byte_s1;
				end
			end
			sfl_pkg::PH_LOAD: begin
				if (kind_s1) begin
					tick_cnt_d = tick_inc;
					if (tick_hit) begin
						tick_cnt_d  = '0;
						byte_cnt_d  = '0;
						retry_cnt_d = retry_inc;
						if (retry_inc >= max_retries_q) begin
							phase_d = sfl_pkg::PH_STOPPED;
						end
					end
				end else begin
					tick_cnt_d = '0;
					byte_cnt_d = byte_cnt_q + 1'b1;
					if (pkt_full) begin
						byte_cnt_d  = '0;
						retry_cnt_d = '0;
						if (region_done) begin
							phase_d = sfl_pkg::PH_STOPPED;
						end else begin
							wr_addr_d = wr_addr_q + AW'(WORDS_PER_BLOCK);
							blk_d     = blk_q + 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Result group selection for the current event.
	// ------------------------------------------------------------------
	always_comb begin
		grp_load   = 1'b0;
		grp_kind_d = sfl_pkg::GRP_HS_TO;
		grp_addr_d = '0;
		case (phase_q)
			sfl_pkg::PH_HANDSHAKE: begin
				if (kind_s1) begin
					grp_load = tick_hit;
				end else if (prev_byte_q == sfl_pkg::SYNC_FIRST &&
						byte_s1 == sfl_pkg::SYNC_SECOND) begin
					grp_load   = 1'b1;
					grp_kind_d = sfl_pkg::GRP_HS_OK;
					grp_addr_d = region_start_q;
				end
			end
			sfl_pkg::PH_LOAD: begin
				if (kind_s1) begin
					grp_load   = tick_hit;
					grp_kind_d = (retry_inc >= max_retries_q) ? sfl_pkg::GRP_ABORT
						: sfl_pkg::GRP_PKT_TO;
				end else begin
					grp_load   = pkt_full;
					grp_kind_d = region_done ? sfl_pkg::GRP_PKT_DONE : sfl_pkg::GRP_PKT;
					// Base of the aligned block that holds the write address.
					grp_addr_d = AW'(blk_q * AW'(WORDS_PER_BLOCK));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sfl_pkg::PH_HANDSHAKE;
			prev_byte_q <= '0;
			tick_cnt_q  <= '0;
			byte_cnt_q  <= '0;
			retry_cnt_q <= '0;
			wr_addr_q   <= sfl_pkg::REGION_START_RST;
		end else if (adv_s1) begin
			phase_q     <= phase_d;
			prev_byte_q <= prev_byte_d;
			tick_cnt_q  <= tick_cnt_d;
			byte_cnt_q  <= byte_cnt_d;
			retry_cnt_q <= retry_cnt_d;
			wr_addr_q   <= wr_addr_d;
		end
	end

	// Block number and packet bytes are always written before they are read.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			blk_q <= blk_d;
			if (phase_q == sfl_pkg::PH_LOAD && !kind_s1) begin
				pkt_byte_q[byte_cnt_q] <= byte_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result group register and output sequencing.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			grp_kind_q  <= sfl_pkg::GRP_HS_TO;
			grp_idx_q   <= '0;
		end else if (adv_s1) begin
			grp_valid_q <= grp_load;
			grp_kind_q  <= grp_kind_d;
			grp_idx_q   <= '0;
		end else if (out_fire) begin
			if (grp_idx_q == last_idx) begin
				grp_valid_q <= 1'b0;
			end else begin
				grp_idx_q <= grp_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && grp_load) begin
			grp_addr_q <= grp_addr_d;
			grp_word_q <= grp_word_d;
		end
	end

	always_comb begin
		last_idx = '0;
		out_code = sfl_pkg::EV_HS_TO;
		out_addr = '0;
		out_word = '0;
		case (grp_kind_q)
			sfl_pkg::GRP_HS_TO: begin
				out_code = sfl_pkg::EV_HS_TO;
			end
			sfl_pkg::GRP_HS_OK: begin
				last_idx = IDXW'(1);
				if (grp_idx_q == '0) begin
					out_code = sfl_pkg::EV_HS_OK;
				end else begin
					out_code = sfl_pkg::EV_ERASE;
					out_addr = grp_addr_q;
				end
			end
			sfl_pkg::GRP_PKT_TO: begin
				out_code = sfl_pkg::EV_PKT_TO;
			end
			sfl_pkg::GRP_ABORT: begin
				last_idx = IDXW'(1);
				out_code = (grp_idx_q == '0) ? sfl_pkg::EV_PKT_TO : sfl_pkg::EV_ABORT;
			end
			sfl_pkg::GRP_PKT, sfl_pkg::GRP_PKT_DONE: begin
				last_idx = (grp_kind_q == sfl_pkg::GRP_PKT_DONE) ? IDXW'(WORDS_PER_BLOCK)
					: IDXW'(WORDS_PER_BLOCK - 1);
				if (grp_idx_q < IDXW'(WORDS_PER_BLOCK)) begin
					out_code = sfl_pkg::EV_WRITE;
					// Word addresses wrap within the address width.
					out_addr = grp_addr_q + AW'(grp_idx_q);
					out_word = grp_word_q[grp_idx_q[WIDX-1:0]];
				end else begin
					out_code = sfl_pkg::EV_DONE;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = grp_valid_q;
	assign m_axis_tuser  = out_code;
	assign m_axis_tdata  = {5'b0, out_word, out_addr};
	assign m_axis_tlast  = grp_idx_q == last_idx;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// Once stopped, only reset leaves the stopped phase.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sfl_pkg::PH_STOPPED |=> phase_q == sfl_pkg::PH_STOPPED)
		else $error("sequencer left the stopped phase");

	// The drain index never runs past the last result of its group.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid_q |-> grp_idx_q <= last_idx)
		else $error("result index beyond its group");

	// Input backpressure only while an event waits in the input register.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && grp_valid_q)
		else $error("input stalled with no pending work");

	// A stopped sequencer never starts a new result group.
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && phase_q == sfl_pkg::PH_STOPPED |=> !grp_valid_q)
		else $error("result produced while stopped");

endmodule
